// ===== design/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the stuffed frame checker
// Byte codes of the framing, status codes, the result record and the
// byte-wide CRC-16/KERMIT update.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'hF8;
  localparam logic [7:0] START_BYTE = 8'hFB;
  localparam logic [7:0] STOP_BYTE  = 8'hFE;
  localparam logic [7:0] PRE_BYTE   = 8'hFF;
  localparam logic [7:0] RC_PLAIN   = 8'h00;
  localparam logic [7:0] RC_ALT     = 8'h10;
  localparam logic [7:0] ESC_MAX    = 8'h03;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [7:0] REG_OWN_ADDR  = 8'd0;
  localparam logic [7:0] REG_PEER_ADDR = 8'd1;

  localparam logic [7:0] OWN_ADDR_RST  = 8'h11;
  localparam logic [7:0] PEER_ADDR_RST = 8'h3F;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_PREAMBLE = 4'd1;
  localparam logic [3:0] ST_START    = 4'd2;
  localparam logic [3:0] ST_DEST     = 4'd3;
  localparam logic [3:0] ST_SRC      = 4'd4;
  localparam logic [3:0] ST_REPLY    = 4'd5;
  localparam logic [3:0] ST_ESCAPE   = 4'd6;
  localparam logic [3:0] ST_SHORT    = 4'd7;
  localparam logic [3:0] ST_CRC      = 4'd8;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       last;
    logic [3:0] status;
    logic [7:0] command;
    logic [7:0] reply_code;
  } result_t;

  // Maps the escape follower 0..3 to the byte it stands for.
  function automatic logic [7:0] unescape(input logic [1:0] code);
    logic [7:0] v;
    case (code)
      2'd0:    v = 8'hF8;
      2'd1:    v = 8'hFB;
      2'd2:    v = 8'hFD;
      default: v = 8'hFE;
    endcase
    return v;
  endfunction

  // Reflected CRC-16 update by one byte, LSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] c_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sfc_out_buf.sv =====
// ----------------------------------------------------------------------------
// sfc_out_buf: two-entry result buffer
// An output register backed by a skid register, so the checker keeps taking
// bytes while a finished result waits for its transfer.
// ----------------------------------------------------------------------------
module sfc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfc_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output sfc_pkg::result_t out_data
);
  import sfc_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      // Output held by the consumer: park the new result.
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into a full buffer");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !out_ready) |=> (main_valid_r && $stable(main_r)))
    else $error("stalled result changed");

endmodule

// ===== design/stuffed_frame_checker_crc16.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_checker_crc16: deframer and CRC-16/KERMIT checker
// Checks preamble, start byte and addresses of a reply frame, un-escapes the
// body, forwards payload two bytes late and reports one status at the stop.
// ----------------------------------------------------------------------------
// A result is offered on out_valid in the cycle after the input transfer of the
// byte that causes it when the output register is free; a result parked in the
// skid register waits until the one ahead of it has been taken.
// Throughput: one byte per cycle while in_ready is high; the header check, unescape
// and byte-wide CRC update sit between the frame state registers and a two-entry
// result buffer. in_ready drops only when both result entries are occupied.
// Reset (synchronous, rst_n low): addresses return to 0x11 and 0x3F, the frame
// state is cleared and the result buffer is emptied.
module stuffed_frame_checker_crc16 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_status,
  output logic       out_last,
  output logic [3:0] out_status,
  output logic [7:0] out_command,
  output logic [7:0] out_reply_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sfc_pkg::*;

  typedef enum logic [2:0] {
    PH_PRE0, PH_PRE1, PH_START, PH_DEST, PH_SRC, PH_CMD, PH_RC, PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic        disc_r, disc_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  rc_r, rc_nxt;
  logic [7:0]  own_r, peer_r;

  logic        in_fire;
  logic        push;
  result_t     res;
  result_t     out_data;
  logic        space;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign in_fire   = in_valid && in_ready;

  function automatic logic [3:0] header_check(input phase_t p, input logic [7:0] b,
                                              input logic [7:0] own,
                                              input logic [7:0] peer);
    logic [3:0] e;
    case (p)
      PH_PRE0, PH_PRE1: e = (b == PRE_BYTE)   ? ST_OK : ST_PREAMBLE;
      PH_START:         e = (b == START_BYTE) ? ST_OK : ST_START;
      PH_DEST:          e = (b == own)        ? ST_OK : ST_DEST;
      PH_SRC:           e = (b == peer)       ? ST_OK : ST_SRC;
      PH_CMD:           e = ST_OK;
      default:          e = (b == RC_PLAIN || b == RC_ALT) ? ST_OK : ST_REPLY;
    endcase
    return e;
  endfunction

  always_comb begin
    logic [3:0] hchk;
    logic [3:0] st;
    logic       have_v;
    logic [7:0] v;
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    disc_nxt  = disc_r;
    err_nxt   = err_r;
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    rc_nxt    = rc_r;
    push      = 1'b0;
    res       = '0;
    have_v    = 1'b0;
    v         = in_byte;
    st        = ST_OK;
    hchk      = header_check(phase_r, in_byte, own_r, peer_r);

    if (in_fire) begin
      if (in_byte == STOP_BYTE) begin
        if (disc_r) begin
          st = err_r;
        end else if (phase_r != PH_BODY) begin
          st = (hchk == ST_OK) ? ST_SHORT : hchk;
        end else if (esc_r) begin
          st = ST_ESCAPE;
        end else if (cnt_r != 2'd2) begin
          st = ST_SHORT;
        end else begin
          st = (held0_r == crc_r[7:0] && held1_r == crc_r[15:8]) ? ST_OK : ST_CRC;
        end
        push           = 1'b1;
        res.is_status  = 1'b1;
        res.last       = 1'b1;
        res.status     = st;
        res.command    = cmd_r;
        res.reply_code = rc_r;
        phase_nxt = PH_PRE0;
        esc_nxt   = 1'b0;
        disc_nxt  = 1'b0;
        err_nxt   = ST_OK;
        crc_nxt   = '0;
        held0_nxt = '0;
        held1_nxt = '0;
        cnt_nxt   = '0;
        cmd_nxt   = '0;
        rc_nxt    = '0;
      end else if (!disc_r) begin
        if (phase_r != PH_BODY) begin
          if (hchk != ST_OK) begin
            disc_nxt = 1'b1;
            err_nxt  = hchk;
          end else begin
            // The CRC restarts at the start byte and runs over the header.
            if (phase_r == PH_START) begin
              crc_nxt = crc16_feed(16'h0000, in_byte);
            end else if (phase_r != PH_PRE0 && phase_r != PH_PRE1) begin
              crc_nxt = crc16_feed(crc_r, in_byte);
            end
            if (phase_r == PH_CMD) begin
              cmd_nxt = in_byte;
            end
            if (phase_r == PH_RC) begin
              rc_nxt = in_byte;
            end
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          if (in_byte > ESC_MAX) begin
            disc_nxt = 1'b1;
            err_nxt  = ST_ESCAPE;
          end else begin
            v      = unescape(in_byte[1:0]);
            have_v = 1'b1;
          end
        end else if (in_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          have_v = 1'b1;
        end

        if (have_v) begin
          // The two newest body bytes are held back as the candidate CRC.
          if (cnt_r == 2'd2) begin
            push         = 1'b1;
            res.out_byte = held0_r;
            crc_nxt      = crc16_feed(crc_r, held0_r);
            held0_nxt    = held1_r;
            held1_nxt    = v;
          end else begin
            if (cnt_r[0]) begin
              held1_nxt = v;
            end else begin
              held0_nxt = v;
            end
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE0;
      esc_r   <= 1'b0;
      disc_r  <= 1'b0;
      err_r   <= ST_OK;
      crc_r   <= '0;
      cnt_r   <= '0;
      cmd_r   <= '0;
      rc_r    <= '0;
      own_r   <= OWN_ADDR_RST;
      peer_r  <= PEER_ADDR_RST;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      disc_r  <= disc_nxt;
      err_r   <= err_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      rc_r    <= rc_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OWN_ADDR) begin
          own_r <= cfg_data;
        end else if (cfg_index == REG_PEER_ADDR) begin
          peer_r <= cfg_data;
        end
      end
    end
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

  sfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte       = out_data.out_byte;
  assign out_is_status  = out_data.is_status;
  assign out_last       = out_data.last;
  assign out_status     = out_data.status;
  assign out_command    = out_data.command;
  assign out_reply_code = out_data.reply_code;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("held byte count out of range");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_byte == STOP_BYTE) |=> (phase_r == PH_PRE0 && !disc_r && !esc_r
                                           && cnt_r == 2'd0))
    else $error("frame state not cleared after the stop byte");

  a_body_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0 || esc_r) |-> (phase_r == PH_BODY))
    else $error("body state set outside the body");

  a_payload_two_late: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !res.is_status) |-> (cnt_r == 2'd2 && !disc_r))
    else $error("payload result without two held bytes");

endmodule
